[hdl/aec_pkg.sv]
// Shared types, constants and AES round functions for the packet cipher.
// Used by aec_kexp, aec_dp, aec_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
package aec_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_W0     = 3'd0;
  localparam logic [2:0] REG_KEY_W1     = 3'd1;
  localparam logic [2:0] REG_KEY_W2     = 3'd2;
  localparam logic [2:0] REG_KEY_W3     = 3'd3;
  localparam logic [2:0] REG_KEY_SIZE   = 3'd4;
  localparam logic [2:0] REG_CHAIN_MODE = 3'd5;
  localparam logic [2:0] REG_IV_HIGH    = 3'd6;
  localparam logic [2:0] REG_IV_LOW     = 3'd7;

  localparam logic [1:0] KEY_SIZE_128 = 2'd0;
  localparam logic [1:0] KEY_SIZE_192 = 2'd1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam int RK_ENTRIES = 30;

  // controller to datapath
  typedef struct packed {
    logic       accept;     // input beat taken this cycle
    logic       exp_start;  // start round key expansion
    logic       round_en;   // perform one round step
    logic       first;      // step is the initial key add
    logic       last;       // step is the final round
    logic [3:0] rk_round;   // round key to fetch for the next cycle
  } aec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       keys_ready;
    logic       exp_done;
    logic [3:0] num_rounds;
  } aec_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte n of the state sits at bits 127-8n down
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int n = 0; n < 16; n++) begin
      t[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
        t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = s[127-8*(4*c+k) -: 8];
        a2[k] = xt(a[k]);
        a4[k] = xt(a2[k]);
        a8[k] = xt(a4[k]);
        m2[k] = a2[k];
        m3[k] = a2[k] ^ a[k];
        m9[k] = a8[k] ^ a[k];
        mb[k] = a8[k] ^ a2[k] ^ a[k];
        md[k] = a8[k] ^ a4[k] ^ a[k];
        me[k] = a8[k] ^ a4[k] ^ a2[k];
      end
      if (inv) begin
        t[127-8*(4*c+0) -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
        t[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
        t[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
        t[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end else begin
        t[127-8*(4*c+0) -: 8] = m2[0] ^ m3[1] ^ a[2] ^ a[3];
        t[127-8*(4*c+1) -: 8] = a[0] ^ m2[1] ^ m3[2] ^ a[3];
        t[127-8*(4*c+2) -: 8] = a[0] ^ a[1] ^ m2[2] ^ m3[3];
        t[127-8*(4*c+3) -: 8] = m3[0] ^ a[1] ^ a[2] ^ m2[3];
      end
    end
    mix_columns = t;
  endfunction

endpackage

[hdl/aec_kexp.sv]
// Iterative AES key expansion: one 32-bit key word per cycle, written in pairs.
// Depends on aec_pkg (S-box, xtime).
`timescale 1ns / 1ps
module aec_kexp (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] key,
  input  logic [1:0]   key_size,
  output logic         done,
  output logic         wr_en,
  output logic [4:0]   wr_addr,
  output logic [63:0]  wr_data
);

  logic        busy_r, busy_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [2:0]  mod_r, mod_nxt;
  logic [7:0]  rcon_r, rcon_nxt;
  logic [31:0] win_r [8];
  logic [31:0] new_word;
  logic [31:0] tmp;
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [2:0]  back_idx;
  logic        last;

  // word count and window tap per key length
  always_comb begin
    if (key_size == aec_pkg::KEY_SIZE_128) begin
      nk = 4'd4; total = 6'd44;
    end else if (key_size == aec_pkg::KEY_SIZE_192) begin
      nk = 4'd6; total = 6'd52;
    end else begin
      nk = 4'd8; total = 6'd60;
    end
    back_idx = 3'(4'd8 - nk);
  end

  // next word: straight from the key, or the recurrence on the window
  always_comb begin
    tmp = win_r[7];
    rcon_nxt = rcon_r;
    if ({1'b0, idx_r} < {3'd0, nk}) begin
      new_word = key[255 - 32*idx_r[2:0] -: 32];
    end else begin
      if (mod_r == 3'd0) begin
        tmp = aec_pkg::sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rcon_r, 24'd0};
        rcon_nxt = aec_pkg::xt(rcon_r);
      end else if (nk == 4'd8 && mod_r == 3'd4) begin
        tmp = aec_pkg::sub_word(win_r[7]);
      end
      new_word = win_r[back_idx] ^ tmp;
    end
  end

  assign last    = busy_r && (idx_r == total - 6'd1);
  assign done    = last;
  assign wr_en   = busy_r && idx_r[0];
  assign wr_addr = idx_r[5:1];
  assign wr_data = {win_r[7], new_word};

  // counters
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    mod_nxt  = mod_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = 6'd0;
      mod_nxt  = 3'd0;
    end else if (busy_r) begin
      busy_nxt = !last;
      idx_nxt  = idx_r + 6'd1;
      mod_nxt  = ({1'b0, mod_r} == nk - 4'd1) ? 3'd0 : mod_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 6'd0;
      mod_r  <= 3'd0;
      rcon_r <= 8'h01;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      mod_r  <= mod_nxt;
      if (start) begin
        rcon_r <= 8'h01;
      end else if (busy_r) begin
        rcon_r <= rcon_nxt;
      end
    end
  end

  // sliding window of the last eight words
  always_ff @(posedge clk) begin
    if (busy_r) begin
      for (int k = 0; k < 7; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[7] <= new_word;
    end
  end

endmodule

[hdl/aec_dp.sv]
// Datapath: configuration registers, round key memory, AES round unit,
// chain register and output register. Depends on aec_pkg and aec_kexp.
`timescale 1ns / 1ps
module aec_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  aec_pkg::aec_cmd_t cmd,
  output aec_pkg::aec_sts_t sts,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_operation,
  input  logic              in_packet_start,
  input  logic [4:0]        in_valid_bytes,
  input  logic [127:0]      in_block,
  output logic [131:0]      out_payload
);

  logic [63:0]  key_r [4];
  logic [1:0]   key_size_r;
  logic         chain_mode_r;
  logic [127:0] iv_r;
  logic         keys_ready_r;
  logic [127:0] chain_r;
  logic [127:0] prev_r;
  logic [127:0] state_r;
  logic         dec_r;
  logic         cbc_r;
  logic [3:0]   pad_r;
  logic [127:0] out_data_r;
  logic [3:0]   out_pad_r;
  logic [63:0]  rk_mem [aec_pkg::RK_ENTRIES];
  logic [63:0]  rk_hi_r, rk_lo_r;

  logic         exp_done;
  logic         exp_we;
  logic [4:0]   exp_addr;
  logic [63:0]  exp_data;

  logic [4:0]   vb;
  logic [127:0] padded;
  logic [127:0] chain_sel;
  logic [127:0] rk;
  logic [127:0] step_val;
  logic [127:0] enc_core, dec_core;

  aec_kexp u_kexp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exp_start),
    .key      ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .key_size (key_size_r),
    .done     (exp_done),
    .wr_en    (exp_we),
    .wr_addr  (exp_addr),
    .wr_data  (exp_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        key_r[k] <= 64'd0;
      end
      key_size_r   <= 2'd0;
      chain_mode_r <= 1'b0;
      iv_r         <= 128'd0;
      keys_ready_r <= 1'b0;
    end else begin
      if (exp_done) begin
        keys_ready_r <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          aec_pkg::REG_KEY_W0: begin key_r[0] <= cfg_data; keys_ready_r <= 1'b0; end
          aec_pkg::REG_KEY_W1: begin key_r[1] <= cfg_data; keys_ready_r <= 1'b0; end
          aec_pkg::REG_KEY_W2: begin key_r[2] <= cfg_data; keys_ready_r <= 1'b0; end
          aec_pkg::REG_KEY_W3: begin key_r[3] <= cfg_data; keys_ready_r <= 1'b0; end
          aec_pkg::REG_KEY_SIZE: begin
            key_size_r   <= cfg_data[1:0];
            keys_ready_r <= 1'b0;
          end
          aec_pkg::REG_CHAIN_MODE: chain_mode_r <= cfg_data[0];
          aec_pkg::REG_IV_HIGH:    iv_r[127:64] <= cfg_data;
          aec_pkg::REG_IV_LOW:     iv_r[63:0]   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign sts.keys_ready = keys_ready_r;
  assign sts.exp_done   = exp_done;
  assign sts.num_rounds = (key_size_r == aec_pkg::KEY_SIZE_128) ? 4'd10 :
                          (key_size_r == aec_pkg::KEY_SIZE_192) ? 4'd12 : 4'd14;

  // round key memory: one write port, two registered reads for one round key
  always_ff @(posedge clk) begin
    if (exp_we) begin
      rk_mem[exp_addr] <= exp_data;
    end
    rk_hi_r <= rk_mem[{cmd.rk_round, 1'b0}];
    rk_lo_r <= rk_mem[{cmd.rk_round, 1'b1}];
  end
  assign rk = {rk_hi_r, rk_lo_r};

  // zero the bytes past the valid count; pick the IV at packet start, else the chain
  always_comb begin
    vb = (in_valid_bytes > 5'd16) ? 5'd16 : in_valid_bytes;
    for (int n = 0; n < 16; n++) begin
      padded[127-8*n -: 8] = (5'(n) < vb) ? in_block[127-8*n -: 8] : 8'h00;
    end
    chain_sel = in_packet_start ? iv_r : chain_r;
  end

  // one round step
  always_comb begin
    enc_core = aec_pkg::shift_rows(aec_pkg::sub_bytes(state_r, 1'b0), 1'b0);
    dec_core = aec_pkg::sub_bytes(aec_pkg::shift_rows(state_r, 1'b1), 1'b1);
    if (cmd.first) begin
      step_val = state_r ^ rk;
    end else if (dec_r) begin
      step_val = cmd.last ? (dec_core ^ rk)
                          : aec_pkg::mix_columns(dec_core ^ rk, 1'b1);
    end else begin
      step_val = cmd.last ? (enc_core ^ rk)
                          : (aec_pkg::mix_columns(enc_core, 1'b0) ^ rk);
    end
  end

  // chain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= 128'd0;
    end else if (cmd.accept) begin
      chain_r <= (chain_mode_r && in_operation == aec_pkg::OP_DECRYPT) ? padded : chain_sel;
    end else if (cmd.round_en && cmd.last && cbc_r && !dec_r) begin
      chain_r <= step_val;
    end
  end

  // block state and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      state_r <= (chain_mode_r && in_operation == aec_pkg::OP_ENCRYPT) ?
                 (padded ^ chain_sel) : padded;
      prev_r  <= chain_sel;
      dec_r   <= in_operation;
      cbc_r   <= chain_mode_r;
      pad_r   <= 4'(5'd16 - vb);
    end else if (cmd.round_en) begin
      state_r <= step_val;
    end
    if (cmd.round_en && cmd.last) begin
      out_data_r <= (cbc_r && dec_r) ? (step_val ^ prev_r) : step_val;
      out_pad_r  <= pad_r;
    end
  end

  assign out_payload = {out_pad_r, out_data_r[63:0], out_data_r[127:64]};

endmodule

[hdl/aec_ctrl.sv]
// Controller: accepts beats, sequences key expansion and the AES rounds,
// owns the output valid flag. Depends on aec_pkg.
`timescale 1ns / 1ps
module aec_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_operation,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  aec_pkg::aec_sts_t sts,
  output aec_pkg::aec_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPAND = 4'b0010,
    ST_KEYRD  = 4'b0100,
    ST_ROUND  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       op_r;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;
  logic       last;
  logic       round_en;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign last      = (step_r == sts.num_rounds);
  // the final round waits for room in the output register
  assign round_en  = (state_r == ST_ROUND) && (!last || out_free);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = sts.keys_ready ? ST_KEYRD : ST_EXPAND;
          step_nxt  = 4'd0;
        end
      end
      ST_EXPAND: begin
        if (sts.exp_done) begin
          state_nxt = ST_KEYRD;
        end
      end
      ST_KEYRD: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (round_en) begin
          if (last) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 4'd0;
      op_r        <= aec_pkg::OP_ENCRYPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        op_r <= in_operation;
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign cmd.accept    = accept;
  assign cmd.exp_start = accept && !sts.keys_ready;
  assign cmd.round_en  = round_en;
  assign cmd.first     = (step_r == 4'd0);
  assign cmd.last      = last;
  // fetch the key of the step that runs next cycle
  assign cmd.rk_round  = (op_r == aec_pkg::OP_DECRYPT) ? (sts.num_rounds - step_nxt) : step_nxt;

endmodule

[hdl/aes_ecb_cbc_packet_cipher.sv]
// AES ECB/CBC packet cipher, one 128-bit block per beat.
// After an input beat the block passes one key fetch state and Nr + 1 round steps
// (Nr = 10, 12 or 14) before output valid, and the first block after a key or key size
// write waits first for key expansion of 44, 52 or 60 words. The single shared round unit
// holds one block at a time: a new beat is taken only in the idle state.
// Reset: synchronous active-low rst_n clears configuration, chain and valid flags.
`timescale 1ns / 1ps
module aes_ecb_cbc_packet_cipher (
  input  logic         clk,
  input  logic         rst_n,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // valid_bytes[4:0], block_high[68:5], block_low[132:69]
  input  logic [1:0]   in_tuser,  // operation[0], packet_start[1]
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata  // out_high[63:0], out_low[127:64], pad_count[131:128]
);

  aec_pkg::aec_cmd_t cmd;
  aec_pkg::aec_sts_t sts;
  logic [131:0]      payload;

  assign cfg_ready = 1'b1;

  aec_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_operation (in_tuser[0]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .sts          (sts),
    .cmd          (cmd)
  );

  aec_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_operation    (in_tuser[0]),
    .in_packet_start (in_tuser[1]),
    .in_valid_bytes  (in_tdata[4:0]),
    .in_block        ({in_tdata[68:5], in_tdata[132:69]}),
    .out_payload     (payload)
  );

  assign out_tdata = {4'd0, payload};

endmodule

[test/tb_aes_ecb_cbc_packet_cipher.sv]
// Self-checking bench for the AES ECB/CBC packet cipher: random and directed
// blocks, configuration phases, and an in-bench AES predictor.
// Depends on hdl/aec_pkg.sv (register codes, S-boxes) and the top level RTL.
`timescale 1ns / 1ps
module tb_aes_ecb_cbc_packet_cipher;

  typedef struct {
    logic        op;
    logic        pstart;
    logic [4:0]  vbytes;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [3:0]  pad;
  } res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;

  aes_ecb_cbc_packet_cipher dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the configuration and chain
  logic [63:0]  sh_key [4];
  logic [1:0]   sh_ksize;
  logic         sh_cbc;
  logic [63:0]  sh_iv_hi, sh_iv_lo;
  logic [127:0] sh_chain;
  logic [127:0] rkeys [15];
  int           nrounds;

  blk_t  block_q [$];
  res_t  cipher_q [$];
  blk_t  cur_blk;
  int    errors = 0;
  int    idle_cycles = 0;

  // ---------------- AES predictor ----------------
  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  function automatic logic [127:0] do_sub(logic [127:0] s, bit dec);
    for (int n = 0; n < 16; n++)
      s[127-8*n -: 8] = dec ? aec_pkg::INV_SBOX[s[127-8*n -: 8]]
                            : aec_pkg::SBOX[s[127-8*n -: 8]];
    return s;
  endfunction

  function automatic logic [127:0] do_shift(logic [127:0] s, bit dec);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = dec ? ((c + 4 - r) & 3) : ((c + r) & 3);
        t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
      end
    return t;
  endfunction

  function automatic logic [127:0] do_mix(logic [127:0] s, bit dec);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] m [4];
    if (dec)
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[127-8*(4*c+k) -: 8];
      for (int k = 0; k < 4; k++)
        t[127-8*(4*c+k) -: 8] = gf_mul(a[0], m[(4-k)&3]) ^ gf_mul(a[1], m[(5-k)&3]) ^
                                gf_mul(a[2], m[(6-k)&3]) ^ gf_mul(a[3], m[(7-k)&3]);
    end
    return t;
  endfunction

  // key size three behaves as 256 bits
  function automatic void build_schedule();
    logic [255:0] key;
    logic [31:0]  w [60];
    logic [31:0]  t;
    logic [7:0]   rc;
    int nk, total;
    key = {sh_key[0], sh_key[1], sh_key[2], sh_key[3]};
    nk = (sh_ksize == aec_pkg::KEY_SIZE_128) ? 4 :
         (sh_ksize == aec_pkg::KEY_SIZE_192) ? 6 : 8;
    nrounds = nk + 6;
    total = 4 * (nrounds + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++) w[i] = key[255-32*i -: 32];
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {aec_pkg::SBOX[t[31:24]], aec_pkg::SBOX[t[23:16]],
             aec_pkg::SBOX[t[15:8]], aec_pkg::SBOX[t[7:0]]} ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {aec_pkg::SBOX[t[31:24]], aec_pkg::SBOX[t[23:16]],
             aec_pkg::SBOX[t[15:8]], aec_pkg::SBOX[t[7:0]]};
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r <= nrounds; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] aes_block(logic [127:0] s, bit dec);
    if (!dec) begin
      s ^= rkeys[0];
      for (int r = 1; r < nrounds; r++)
        s = do_mix(do_shift(do_sub(s, 0), 0), 0) ^ rkeys[r];
      s = do_shift(do_sub(s, 0), 0) ^ rkeys[nrounds];
    end else begin
      s ^= rkeys[nrounds];
      for (int r = nrounds - 1; r >= 1; r--)
        s = do_mix(do_sub(do_shift(s, 1), 1) ^ rkeys[r], 1);
      s = do_sub(do_shift(s, 1), 1) ^ rkeys[0];
    end
    return s;
  endfunction

  // expected result of one block, loading the chain at packet start and advancing it in CBC
  function automatic res_t cipher_predict(blk_t b);
    res_t r;
    logic [127:0] s;
    int v;
    v = (b.vbytes > 16) ? 16 : b.vbytes;
    build_schedule();
    if (b.pstart) sh_chain = {sh_iv_hi, sh_iv_lo};
    s = {b.hi, b.lo};
    for (int n = v; n < 16; n++) s[127-8*n -: 8] = 8'h00;
    if (sh_cbc && b.op == aec_pkg::OP_ENCRYPT) begin
      s = aes_block(s ^ sh_chain, 0);
      sh_chain = s;
    end else if (sh_cbc) begin
      r.hi = s[127:64];
      s = aes_block(s, 1) ^ sh_chain;
      sh_chain = {r.hi, b.lo};
      for (int n = v; n < 16; n++) sh_chain[127-8*n -: 8] = 8'h00;
    end else begin
      s = aes_block(s, b.op == aec_pkg::OP_DECRYPT);
    end
    r.hi = s[127:64];
    r.lo = s[63:0];
    r.pad = 4'((16 - v) & 15);
    return r;
  endfunction

  // ---------------- sender: bursts and gaps ----------------
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) cipher_q.push_back(cipher_predict(cur_blk));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (block_q.size() > 0) begin
          cur_blk = block_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {3'b0, cur_blk.lo, cur_blk.hi, cur_blk.vbytes};
          in_tuser <= {cur_blk.pstart, cur_blk.op};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver: stall pattern and checks ----------------
  int rx_cycle = 0, rx_mode = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 300 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : chk
    res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        $error("result beat with no block outstanding: %h", out_tdata);
        errors++;
      end else begin
        e = cipher_q.pop_front();
        if (out_tdata[63:0] !== e.hi) begin
          $error("out_high expected %h got %h", e.hi, out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== e.lo) begin
          $error("out_low expected %h got %h", e.lo, out_tdata[127:64]);
          errors++;
        end
        if (out_tdata[131:128] !== e.pad) begin
          $error("pad_count expected %0d got %0d", e.pad, out_tdata[131:128]);
          errors++;
        end
      end
    end
  end

  // watchdog on beats of any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- sequencing ----------------
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      aec_pkg::REG_KEY_W0, aec_pkg::REG_KEY_W1,
      aec_pkg::REG_KEY_W2, aec_pkg::REG_KEY_W3: sh_key[idx] = val;
      aec_pkg::REG_KEY_SIZE:   sh_ksize = val[1:0];
      aec_pkg::REG_CHAIN_MODE: sh_cbc = val[0];
      aec_pkg::REG_IV_HIGH:    sh_iv_hi = val;
      default:                 sh_iv_lo = val;
    endcase
  endtask

  // settled values at the falling edge: nothing queued, offered or owed
  task automatic drain();
    do @(negedge clk);
    while (block_q.size() > 0 || in_tvalid || cipher_q.size() > 0 || out_tvalid);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_block(logic op, logic ps, logic [4:0] vb,
                                    logic [63:0] hi, logic [63:0] lo);
    blk_t b;
    b.op = op; b.pstart = ps; b.vbytes = vb; b.hi = hi; b.lo = lo;
    block_q.push_back(b);
  endfunction

  // packets of mostly well-formed blocks, with some odd lengths, stray starts and flipped operations
  function automatic void add_packets(int count);
    int len;
    logic op;
    while (count > 0) begin
      len = $urandom_range(1, 8);
      op = $urandom_range(0, 1);
      for (int i = 0; i < len && count > 0; i++, count--)
        add_block(($urandom_range(0, 9) == 0) ? ~op : op,
                  (i == 0) || ($urandom_range(0, 15) == 0),
                  ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'd16,
                  rnd64(), rnd64());
    end
  endfunction

  initial begin
    sh_key = '{default: 64'h0};
    sh_ksize = aec_pkg::KEY_SIZE_128;
    sh_cbc = 1'b0;
    sh_iv_hi = '0; sh_iv_lo = '0; sh_chain = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: all-zero key, ECB, start marks load the chain
    add_block(aec_pkg::OP_ENCRYPT, 1'b0, 5'd16, '0, '0);
    add_block(aec_pkg::OP_DECRYPT, 1'b1, 5'd16, '1, '1);
    add_block(aec_pkg::OP_ENCRYPT, 1'b1, 5'd0, '1, '1);
    add_block(aec_pkg::OP_DECRYPT, 1'b0, 5'd1, '1, '1);
    drain();

    // all-ones key at 256 bits, CBC, byte count extremes
    for (int i = 0; i < 4; i++) write_reg(3'(i), '1);
    write_reg(aec_pkg::REG_KEY_SIZE, 64'd2);
    write_reg(aec_pkg::REG_CHAIN_MODE, 64'd1);
    write_reg(aec_pkg::REG_IV_HIGH, '1);
    write_reg(aec_pkg::REG_IV_LOW, 64'h0123456789abcdef);
    add_block(aec_pkg::OP_ENCRYPT, 1'b1, 5'd16, '1, '1);
    add_block(aec_pkg::OP_ENCRYPT, 1'b0, 5'd15, rnd64(), rnd64());
    add_block(aec_pkg::OP_ENCRYPT, 1'b0, 5'd17, rnd64(), rnd64());
    add_block(aec_pkg::OP_DECRYPT, 1'b1, 5'd31, '1, '1);
    add_block(aec_pkg::OP_DECRYPT, 1'b0, 5'd8, rnd64(), rnd64());
    add_block(aec_pkg::OP_DECRYPT, 1'b0, 5'd0, rnd64(), rnd64());
    drain();

    // key size three, then 192 bits with ECB
    write_reg(aec_pkg::REG_KEY_SIZE, 64'd3);
    add_block(aec_pkg::OP_ENCRYPT, 1'b1, 5'd16, rnd64(), rnd64());
    add_block(aec_pkg::OP_DECRYPT, 1'b0, 5'd16, rnd64(), rnd64());
    drain();
    write_reg(aec_pkg::REG_KEY_SIZE, 64'd1);
    write_reg(aec_pkg::REG_CHAIN_MODE, 64'd0);
    add_block(aec_pkg::OP_ENCRYPT, 1'b1, 5'd16, '0, '1);
    add_block(aec_pkg::OP_DECRYPT, 1'b1, 5'd16, '1, '0);
    drain();

    // random phases, each with a fresh setting
    for (int ph = 0; ph < 9; ph++) begin
      for (int i = 0; i < 4; i++)
        if ($urandom_range(0, 2) != 0) write_reg(3'(i), rnd64());
      write_reg(aec_pkg::REG_KEY_SIZE, 64'(ph % 4));
      write_reg(aec_pkg::REG_CHAIN_MODE, 64'($urandom_range(0, 3) != 0));
      write_reg(aec_pkg::REG_IV_HIGH, rnd64());
      write_reg(aec_pkg::REG_IV_LOW, rnd64());
      add_packets(120);
      drain();
    end

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hdl/aec_pkg.sv
hdl/aec_kexp.sv
hdl/aec_dp.sv
hdl/aec_ctrl.sv
hdl/aes_ecb_cbc_packet_cipher.sv
test/tb_aes_ecb_cbc_packet_cipher.sv
